>>> design/mandelbrot_escape_shader_assert.svh
// Assertion macros shared by the escape shader RTL.
// Include with the bare file name; needs nothing else.
`ifndef MANDELBROT_ESCAPE_SHADER_ASSERT_SVH
`define MANDELBROT_ESCAPE_SHADER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mes_pkg.sv
// Shared types and constants of the Mandelbrot escape shader.
// No dependencies.
`default_nettype none

package mes_pkg;

  localparam int PIX_W      = 12;
  localparam int DIM_W      = 13;
  localparam int OFF_W      = 12;
  localparam int ITER_W     = 8;
  localparam int DSL_W      = 30;
  localparam int SHADE_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_LIMIT = 3'd4;

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 13'd1024;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 13'd1024;
  localparam logic [OFF_W-1:0]  RST_ROW_OFFSET   = 12'd0;
  localparam logic [ITER_W-1:0] RST_MAX_ITER     = 8'd200;
  localparam logic [DSL_W-1:0]  RST_DOUBLE_LIMIT = 30'd237265664;

  localparam logic [SHADE_W-1:0] SHADE_MAX = 8'hFF;

  typedef struct packed {
    logic load;
    logic map;
    logic mul;
    logic acc;
    logic upd;
    logic emit;
  } mes_cmd_t;

  typedef struct packed {
    logic div_done;
    logic no_iter;
    logic escaped;
    logic last_iter;
    logic out_free;
  } mes_sts_t;

endpackage

`default_nettype wire

>>> design/mes_div.sv
// Restoring divider, one quotient bit per cycle.
// Needs only the assertion header; used by mes_datapath for the coordinate mapping.
`default_nettype none
`include "mandelbrot_escape_shader_assert.svh"

module mes_div #(
  parameter int NW = 43,
  parameter int DW = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] numer_i,
  input  wire logic [DW-1:0] denom_i,
  output logic      [NW-1:0] quot_o,
  output logic               done_o
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, rem_d, den_q;
  logic [NW-1:0] nq_q, nq_d;
  logic [DW:0]   sh, diff;
  logic          ge;

  always_comb begin
    sh    = {rem_q, nq_q[NW-1]};
    diff  = sh - {1'b0, den_q};
    ge    = (sh >= {1'b0, den_q});
    rem_d = ge ? diff[DW-1:0] : sh[DW-1:0];
    nq_d  = {nq_q[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      nq_q  <= numer_i;
      den_q <= denom_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
    end
  end

  assign quot_o = nq_q;
  assign done_o = (cnt_q == '0);

  `MES_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i, !done_o, "divider idle after start")

endmodule

`default_nettype wire

>>> design/mes_datapath.sv
// Datapath: config registers, coordinate dividers, split multipliers,
// escape test, z update and the output register. Uses mes_pkg, mes_div.
`default_nettype none
`include "mandelbrot_escape_shader_assert.svh"

module mes_datapath #(
  parameter int FRAC_BITS = 28,
  parameter int MAX_DIM   = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire mes_pkg::mes_cmd_t              cmd_i,
  output mes_pkg::mes_sts_t                   sts_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mes_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mes_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [mes_pkg::PIX_W-1:0]      pixel_x_i,
  input  wire logic [mes_pkg::PIX_W-1:0]      pixel_y_i,
  input  wire logic                           out_stall_i,
  output logic                                out_valid_o,
  output logic [mes_pkg::SHADE_W-1:0]         shade_o
);

  localparam int F       = FRAC_BITS;
  localparam int ZW      = F + 4;
  localparam int UW      = ZW + 2;
  localparam int PW      = 2 * ZW;
  localparam int L       = (ZW + 1) / 2;
  localparam int H       = ZW - L;
  localparam int NW      = F + 15;
  localparam int DIM_CAP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam int DW      = $clog2(DIM_CAP + 1);

  localparam logic [NW:0] OFFS_X = {{(NW - F - 1){1'b0}}, 3'b101, {(F - 1){1'b0}}};
  localparam logic [NW:0] OFFS_Y = {{(NW - F){1'b0}}, 3'b101, {(F - 2){1'b0}}};
  localparam logic [PW:0] FOUR   = (PW + 1)'(1) << (2 * F + 2);

  // config
  logic [mes_pkg::DIM_W-1:0]  width_q, height_q;
  logic [mes_pkg::OFF_W-1:0]  offset_q;
  logic [mes_pkg::ITER_W-1:0] iter_q;
  logic [mes_pkg::DSL_W-1:0]  dsl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mes_pkg::RST_IMAGE_WIDTH;
      height_q <= mes_pkg::RST_IMAGE_HEIGHT;
      offset_q <= mes_pkg::RST_ROW_OFFSET;
      iter_q   <= mes_pkg::RST_MAX_ITER;
      dsl_q    <= mes_pkg::RST_DOUBLE_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mes_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[mes_pkg::DIM_W-1:0];
        mes_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[mes_pkg::DIM_W-1:0];
        mes_pkg::CFG_ROW_OFFSET:   offset_q <= cfg_data_i[mes_pkg::OFF_W-1:0];
        mes_pkg::CFG_MAX_ITER:     iter_q   <= cfg_data_i[mes_pkg::ITER_W-1:0];
        mes_pkg::CFG_DOUBLE_LIMIT: dsl_q    <= cfg_data_i[mes_pkg::DSL_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] clamp_dim(input logic [mes_pkg::DIM_W-1:0] d);
    if (d == '0) begin
      return DW'(1);
    end else if (d > mes_pkg::DIM_W'(DIM_CAP)) begin
      return DW'(DIM_CAP);
    end
    return d[DW-1:0];
  endfunction

  function automatic logic [ZW-1:0] sat_map(input logic [NW:0] v);
    logic hi, lo;
    hi = !v[NW] && (|v[NW-1:ZW-1]);
    lo = v[NW] && !(&v[NW-1:ZW-1]);
    if (hi) begin
      return {1'b0, {(ZW - 1){1'b1}}};
    end else if (lo) begin
      return {1'b1, {(ZW - 1){1'b0}}};
    end
    return v[ZW-1:0];
  endfunction

  function automatic logic [ZW-1:0] sat_upd(input logic [UW-1:0] v);
    logic hi, lo;
    hi = !v[UW-1] && (|v[UW-2:ZW-1]);
    lo = v[UW-1] && !(&v[UW-2:ZW-1]);
    if (hi) begin
      return {1'b0, {(ZW - 1){1'b1}}};
    end else if (lo) begin
      return {1'b1, {(ZW - 1){1'b0}}};
    end
    return v[ZW-1:0];
  endfunction

  // coordinate mapping
  logic [14:0]   mul_x;
  logic [12:0]   row;
  logic [15:0]   mul_y;
  logic [NW-1:0] numer_x, numer_y, quot_x, quot_y;
  logic          done_x, done_y;

  always_comb begin
    mul_x   = ({3'b000, pixel_x_i} << 3) - {3'b000, pixel_x_i};
    row     = {1'b0, pixel_y_i} + {1'b0, offset_q};
    mul_y   = ({3'b000, row} << 2) + {3'b000, row};
    numer_x = NW'({mul_x, {(F - 1){1'b0}}});
    numer_y = {mul_y, {(F - 1){1'b0}}};
  end

  mes_div #(.NW(NW), .DW(DW)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .numer_i (numer_x),
    .denom_i (clamp_dim(width_q)),
    .quot_o  (quot_x),
    .done_o  (done_x)
  );

  mes_div #(.NW(NW), .DW(DW)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load),
    .numer_i (numer_y),
    .denom_i (clamp_dim(height_q)),
    .quot_o  (quot_y),
    .done_o  (done_y)
  );

  logic [NW:0] map_x, map_y;

  always_comb begin
    map_x = {1'b0, quot_x} - OFFS_X;
    map_y = {1'b0, quot_y} - OFFS_Y;
  end

  // iteration registers
  logic signed [ZW-1:0] cx_q, cy_q, zx_q, zy_q;
  logic [mes_pkg::ITER_W-1:0]  k_q;
  logic [mes_pkg::SHADE_W-1:0] res_q;

  // multiply stage: magnitudes split in halves
  logic [ZW-1:0] ax, ay;
  logic [L-1:0]  x0, y0;
  logic [H-1:0]  x1, y1;

  always_comb begin
    ax = zx_q[ZW-1] ? ZW'(-zx_q) : zx_q;
    ay = zy_q[ZW-1] ? ZW'(-zy_q) : zy_q;
    x0 = ax[L-1:0];
    x1 = ax[ZW-1:L];
    y0 = ay[L-1:0];
    y1 = ay[ZW-1:L];
  end

  logic [2*L-1:0] pxx00_q, pyy00_q, pxy00_q;
  logic [2*H-1:0] pxx11_q, pyy11_q, pxy11_q;
  logic [ZW-1:0]  pxx01_q, pyy01_q, pxy01_q, pxy10_q;
  logic           sgn_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      pxx00_q <= (2 * L)'(x0) * (2 * L)'(x0);
      pxx11_q <= (2 * H)'(x1) * (2 * H)'(x1);
      pxx01_q <= ZW'(x0) * ZW'(x1);
      pyy00_q <= (2 * L)'(y0) * (2 * L)'(y0);
      pyy11_q <= (2 * H)'(y1) * (2 * H)'(y1);
      pyy01_q <= ZW'(y0) * ZW'(y1);
      pxy00_q <= (2 * L)'(x0) * (2 * L)'(y0);
      pxy11_q <= (2 * H)'(x1) * (2 * H)'(y1);
      pxy01_q <= ZW'(x0) * ZW'(y1);
      pxy10_q <= ZW'(x1) * ZW'(y0);
      sgn_q   <= zx_q[ZW-1] ^ zy_q[ZW-1];
    end
  end

  // accumulate stage: full products
  logic [PW-1:0] sqx_q, sqy_q, sxy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      sqx_q <= {pxx11_q, pxx00_q} + (PW'(pxx01_q) << (L + 1));
      sqy_q <= {pyy11_q, pyy00_q} + (PW'(pyy01_q) << (L + 1));
      sxy_q <= {pxy11_q, pxy00_q} + (PW'(pxy01_q) << L) + (PW'(pxy10_q) << L);
    end
  end

  // update stage: escape test and next z
  logic [PW:0]         mag_sum, limit;
  logic                escaped, dbl, last_iter;
  logic [ZW-1:0]       xx, yy, xy;
  logic signed [UW-1:0] ux, uy, mxy, sxy;
  logic [8:0]          shade_sum;
  logic [mes_pkg::SHADE_W-1:0] shade_sat;

  always_comb begin
    mag_sum   = {1'b0, sqx_q} + {1'b0, sqy_q};
    limit     = (PW + 1)'({dsl_q, {(2 * F - 24){1'b0}}});
    escaped   = (mag_sum > FOUR);
    dbl       = (mag_sum <= limit);
    xx        = sqx_q[F +: ZW];
    yy        = sqy_q[F +: ZW];
    xy        = sxy_q[F +: ZW];
    ux        = $signed({2'b00, xx}) - $signed({2'b00, yy})
              + $signed({{2{cx_q[ZW-1]}}, cx_q});
    mxy       = $signed({2'b00, xy});
    sxy       = sgn_q ? -mxy : mxy;
    uy        = (sxy <<< 1) + $signed({{2{cy_q[ZW-1]}}, cy_q});
    shade_sum = {1'b0, k_q} + (dbl ? 9'd2 : 9'd1);
    shade_sat = shade_sum[8] ? mes_pkg::SHADE_MAX : shade_sum[7:0];
    last_iter = (({1'b0, k_q} + 9'd1) == {1'b0, iter_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map) begin
      cx_q  <= sat_map(map_x);
      cy_q  <= sat_map(map_y);
      zx_q  <= '0;
      zy_q  <= '0;
      k_q   <= '0;
      res_q <= '0;
    end else if (cmd_i.upd) begin
      if (escaped) begin
        res_q <= shade_sat;
      end else begin
        zx_q <= sat_upd(ux);
        zy_q <= sat_upd(uy);
        k_q  <= k_q + mes_pkg::ITER_W'(1);
      end
    end
  end

  // output register
  logic                        out_valid_q;
  logic [mes_pkg::SHADE_W-1:0] shade_q;
  logic                        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      shade_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign shade_o     = shade_q;

  always_comb begin
    sts_o.div_done  = done_x && done_y;
    sts_o.no_iter   = (iter_q == '0);
    sts_o.escaped   = escaped;
    sts_o.last_iter = last_iter;
    sts_o.out_free  = out_free;
  end

  `MES_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, cmd_i.emit, out_valid_q, "emit lost")
  `MES_ASSERT_NEXT(a_no_iter_zero, clk_i, rst_ni, cmd_i.map && sts_o.no_iter, res_q == '0, "zero limit not zero shade")

endmodule

`default_nettype wire

>>> design/mes_ctrl.sv
// Controller FSM: sequences divide, map, multiply, accumulate, update and emit
// steps of the datapath. Uses mes_pkg.
`default_nettype none
`include "mandelbrot_escape_shader_assert.svh"

module mes_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire mes_pkg::mes_sts_t sts_i,
  output mes_pkg::mes_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_MUL  = 6'b000100,
    S_ACC  = 6'b001000,
    S_UPD  = 6'b010000,
    S_FIN  = 6'b100000
  } mes_state_e;

  mes_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.map = 1'b1;
          state_d   = sts_i.no_iter ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = (sts_i.escaped || sts_i.last_iter) ? S_FIN : S_MUL;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  `MES_ASSERT_NEXT(a_accept_div, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_DIV, "accepted beat not dividing")
  `MES_ASSERT_NEXT(a_upd_loop, clk_i, rst_ni, (state_q == S_UPD) && !sts_i.escaped && !sts_i.last_iter, state_q == S_MUL, "iteration dropped early")
  `MES_ASSERT_NOW(a_emit_free, clk_i, rst_ni, cmd_o.emit, sts_i.out_free, "emit into full output")

endmodule

`default_nettype wire

>>> design/mandelbrot_escape_shader.sv
// An accepted beat runs the bit-serial coordinate dividers, then n escape-test
// steps (at most max_iter) of the multiply / accumulate / update loop, then
// emits its result into the output register. One pixel is in flight: a new
// beat is taken only once the controller is idle again, which waits while the
// previous result sits stalled in the output register. Reset: config registers
// take their defaults, controller idle, output not valid, no data clearing.
`default_nettype none

module mandelbrot_escape_shader #(
  parameter int FRAC_BITS = 28,
  parameter int MAX_DIM   = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mes_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mes_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [mes_pkg::PIX_W-1:0]      pixel_x_i,
  input  wire logic [mes_pkg::PIX_W-1:0]      pixel_y_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [mes_pkg::SHADE_W-1:0]         shade_o
);

  mes_pkg::mes_cmd_t cmd;
  mes_pkg::mes_sts_t sts;

  mes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mes_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .shade_o     (shade_o)
  );

endmodule

`default_nettype wire
